// File: rtl/rgb_kernel_blur_macros.svh
// Assertion macros shared by the blur block.
`ifndef RGB_KERNEL_BLUR_MACROS_SVH
`define RGB_KERNEL_BLUR_MACROS_SVH
// Check a property with reset masking.
`define RGBKB_ASSERT(lbl, prop, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rgbkb assertion failed");
// Check a property at every edge, reset included.
`define RGBKB_ASSERT_ALWAYS(lbl, prop, clk) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rgbkb assertion failed");
`endif

// File: rtl/rgbkb_pkg.sv
// Package of shared constants and types for the blur block.
package rgbkb_pkg;
  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxRadius = 2;
  localparam int unsigned KSlots       = 25;
  localparam int unsigned CfgW         = 13;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRadius      = 2'd2;

  localparam logic OpLoadWeight = 1'b0;
  localparam logic OpPixel      = 1'b1;

  localparam logic [10:0] ResetWidth  = 11'd1024;
  localparam logic [12:0] ResetHeight = 13'd1024;
  localparam logic [1:0]  ResetRadius = 2'd1;

  typedef struct packed {
    logic load_weight;
    logic capture;
    logic mem_write;
    logic win_start;
    logic rd_issue;
    logic div_start;
    logic div_step;
    logic out_load;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic interior;
    logic k_last;
    logic div_last;
    logic out_full;
  } status_t;
endpackage

// File: rtl/rgbkb_ifs.sv
// Stream interfaces for the blur block's input and result channels.
interface rgbkb_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [4:0] weight_index;
  logic [7:0] weight_value;
  logic [7:0] pix_r;
  logic [7:0] pix_g;
  logic [7:0] pix_b;
  modport source (output valid, op, weight_index, weight_value, pix_r, pix_g, pix_b,
                  input ready);
  modport sink (input valid, op, weight_index, weight_value, pix_r, pix_g, pix_b,
                output ready);
endinterface

interface rgbkb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_r;
  logic [7:0]  out_g;
  logic [7:0]  out_b;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        zero_weight_sum;
  modport source (output valid, out_r, out_g, out_b, out_row, out_col, zero_weight_sum,
                  input ready);
  modport sink (input valid, out_r, out_g, out_b, out_row, out_col, zero_weight_sum,
                output ready);
endinterface

// File: rtl/rgbkb_ram.sv
// Generic simple dual-port RAM with registered read.
module rgbkb_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// File: rtl/rgbkb_ctrl.sv
// Sequencer for the blur block: weight load, capture, store, window scan, divide, emit.
`include "rgb_kernel_blur_macros.svh"
module rgbkb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_op_i,
  output logic               in_ready_o,
  input  rgbkb_pkg::status_t status_i,
  output rgbkb_pkg::cmd_t    cmd_o
);
  typedef enum logic [2:0] {
    StIdle, StWrite, StRead, StDrain, StLoad, StDiv, StDone
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_op_i == rgbkb_pkg::OpPixel) begin
            cmd_o.capture = 1'b1;
            state_d       = StWrite;
          end else begin
            cmd_o.load_weight = 1'b1;
          end
        end
      end
      StWrite: begin
        cmd_o.mem_write = 1'b1;
        if (status_i.interior) begin
          cmd_o.win_start = 1'b1;
          state_d         = StRead;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = StIdle;
        end
      end
      StRead: begin
        cmd_o.rd_issue = 1'b1;
        if (status_i.k_last) state_d = StDrain;
      end
      StDrain: state_d = StLoad;
      StLoad: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = StDone;
      end
      StDone: begin
        // hold until the result register is free
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          cmd_o.advance  = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `RGBKB_ASSERT(a_pixel_goes_write,
    (accept && in_op_i == rgbkb_pkg::OpPixel) |=> (state_q == StWrite), clk_i, rst_ni)
  `RGBKB_ASSERT(a_scan_stops, (cmd_o.rd_issue && status_i.k_last) |=> !cmd_o.rd_issue,
    clk_i, rst_ni)
  `RGBKB_ASSERT(a_load_free, cmd_o.out_load |-> !status_i.out_full, clk_i, rst_ni)
endmodule

// File: rtl/rgbkb_dp.sv
// Datapath of the blur block: registers, position, line store, MACs, divider.
module rgbkb_dp #(
  parameter int unsigned MaxWidth  = rgbkb_pkg::DefMaxWidth,
  parameter int unsigned MaxRadius = rgbkb_pkg::DefMaxRadius
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rgbkb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rgbkb_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [4:0]                    weight_index_i,
  input  logic [7:0]                    weight_value_i,
  input  logic [23:0]                   pix_i,
  input  rgbkb_pkg::cmd_t               cmd_i,
  output rgbkb_pkg::status_t            status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [23:0]                   out_pix_o,
  output logic [11:0]                   out_row_o,
  output logic [9:0]                    out_col_o,
  output logic                          out_zero_o
);
  localparam int unsigned K   = 2 * MaxRadius + 1;
  localparam int unsigned SLW = $clog2(K);
  localparam int unsigned CW  = $clog2(MaxWidth);
  localparam int unsigned DW  = $clog2(K);
  localparam int unsigned AW  = SLW + CW;
  localparam int unsigned SW  = $clog2(K * K * 255 * 255 + 1);
  localparam int unsigned TW  = $clog2(K * K * 255 + 1);
  localparam int unsigned NW  = $clog2(SW + 1);

  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [1:0]  radius_q;
  logic [12:0] eff_w, eff_h;
  logic [DW-1:0] eff_r, r2;

  always_comb begin
    if (width_q == 11'd0) eff_w = 13'd1;
    else if ({2'b0, width_q} > 13'(MaxWidth)) eff_w = 13'(MaxWidth);
    else eff_w = {2'b0, width_q};
    if (height_q == 13'd0) eff_h = 13'd1;
    else if (height_q > 13'd4096) eff_h = 13'd4096;
    else eff_h = height_q;
    if (32'(radius_q) > MaxRadius) eff_r = DW'(MaxRadius);
    else eff_r = DW'(radius_q);
    r2 = DW'({eff_r, 1'b0});
  end

  logic [11:0]    row_q;
  logic [CW-1:0]  col_q;
  logic [SLW-1:0] slot_q;
  logic [23:0]    pix_q;
  logic [7:0]     weights_q [rgbkb_pkg::KSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rgbkb_pkg::ResetWidth;
      height_q <= rgbkb_pkg::ResetHeight;
      radius_q <= rgbkb_pkg::ResetRadius;
      row_q    <= '0;
      col_q    <= '0;
      slot_q   <= '0;
      for (int i = 0; i < rgbkb_pkg::KSlots; i++) weights_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rgbkb_pkg::RegFrameWidth:  width_q  <= cfg_data_i[10:0];
          rgbkb_pkg::RegFrameHeight: height_q <= cfg_data_i;
          rgbkb_pkg::RegRadius:      radius_q <= cfg_data_i[1:0];
          default: ;
        endcase
        if ((cfg_idx_i == rgbkb_pkg::RegFrameWidth) ||
            (cfg_idx_i == rgbkb_pkg::RegFrameHeight) ||
            (cfg_idx_i == rgbkb_pkg::RegRadius)) begin
          row_q  <= '0;
          col_q  <= '0;
          slot_q <= '0;
        end
      end else if (cmd_i.advance) begin
        if (13'(col_q) + 13'd1 >= eff_w) begin
          col_q <= '0;
          if (13'(row_q) + 13'd1 >= eff_h) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + 12'd1;
            slot_q <= (32'(slot_q) == K - 1) ? '0 : slot_q + SLW'(1);
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (cmd_i.load_weight && 32'(weight_index_i) < rgbkb_pkg::KSlots) begin
        weights_q[weight_index_i] <= weight_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) pix_q <= pix_i;
  end

  assign status_o.interior = (13'(row_q) >= 13'(r2)) && (13'(col_q) >= 13'(r2));

  // window scan counters
  logic [DW-1:0]  wi_q, wj_q;
  logic [SLW-1:0] wslot_q;
  logic [4:0]     widx_q;
  logic [SLW:0]   wslot_init;
  logic [CW-1:0]  wcol;

  assign wslot_init = ((SLW+1)'(slot_q) >= (SLW+1)'(r2)) ?
                      (SLW+1)'(slot_q) - (SLW+1)'(r2) :
                      (SLW+1)'(slot_q) + (SLW+1)'(K) - (SLW+1)'(r2);
  assign wcol = col_q - CW'(r2) + CW'(wj_q);
  assign status_o.k_last = (wi_q == r2) && (wj_q == r2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_start) begin
      wi_q    <= '0;
      wj_q    <= '0;
      widx_q  <= '0;
      wslot_q <= SLW'(wslot_init);
    end else if (cmd_i.rd_issue) begin
      widx_q <= (32'(widx_q) == rgbkb_pkg::KSlots - 1) ? 5'd0 : widx_q + 5'd1;
      if (wj_q == r2) begin
        wj_q    <= '0;
        wi_q    <= wi_q + DW'(1);
        wslot_q <= (32'(wslot_q) == K - 1) ? '0 : wslot_q + SLW'(1);
      end else begin
        wj_q <= wj_q + DW'(1);
      end
    end
  end

  logic [23:0] rdata;
  rgbkb_ram #(.Width(24), .Depth(K << CW)) u_line (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_write),
    .waddr_i ({slot_q, col_q}),
    .wdata_i (pix_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (AW'({wslot_q, wcol})),
    .rdata_o (rdata)
  );

  // multiply-accumulate one window tap per cycle
  logic             rd_v_q;
  logic [7:0]       wt_q;
  logic [2:0][SW-1:0] sum_q;
  logic [TW-1:0]    tot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_v_q <= 1'b0;
    else rd_v_q <= cmd_i.rd_issue;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) wt_q <= weights_q[widx_q];
    if (cmd_i.win_start) begin
      sum_q <= '0;
      tot_q <= '0;
    end else if (rd_v_q) begin
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= sum_q[c] + SW'(wt_q * rdata[8*c +: 8]);
      end
      tot_q <= tot_q + TW'(wt_q);
    end
  end

  // restoring divider, one quotient bit per cycle in all three channels
  logic [2:0][SW-1:0] quo_q;
  logic [2:0][TW-1:0] rem_q;
  logic [NW-1:0]      dcnt_q;
  logic [2:0][TW:0]   trial;

  always_comb begin
    for (int c = 0; c < 3; c++) trial[c] = {rem_q[c], quo_q[c][SW-1]};
  end
  assign status_o.div_last = (32'(dcnt_q) == SW - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q  <= sum_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + NW'(1);
      for (int c = 0; c < 3; c++) begin
        if (trial[c] >= (TW+1)'(tot_q)) begin
          rem_q[c] <= TW'(trial[c] - (TW+1)'(tot_q));
          quo_q[c] <= {quo_q[c][SW-2:0], 1'b1};
        end else begin
          rem_q[c] <= TW'(trial[c]);
          quo_q[c] <= {quo_q[c][SW-2:0], 1'b0};
        end
      end
    end
  end

  // result register
  logic          ovalid_q;
  logic [CW-1:0] ccol;
  logic          zero;

  assign ccol = col_q - CW'(eff_r);
  assign zero = (tot_q == '0);
  assign status_o.out_full = ovalid_q;
  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (cmd_i.out_load) ovalid_q <= 1'b1;
    else if (out_ready_i) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int c = 0; c < 3; c++) out_pix_o[8*c +: 8] <= zero ? 8'd0 : quo_q[c][7:0];
      out_zero_o <= zero;
      out_row_o  <= row_q - 12'(eff_r);
      out_col_o  <= 10'(ccol);
    end
  end
endmodule

// File: rtl/rgb_kernel_blur.sv
// Top level of the normalized RGB convolution blur.
// Usage: program the row width (0), the row count (1) and kernel_radius (2)
// through the write port while the block is idle; each such write restarts the
// frame at row 0, column 0. Load weights with op 0 words (index row*side+col),
// then stream pixels in raster order with op 1 words on in_ch.
// Each interior pixel position yields one result word on out_ch, carrying
// the window centre's row and column; border pixels yield nothing.
// Sequence: a weight word is taken while idle and the block stays idle. A
// pixel word that closes no window is stored, and the block returns to idle.
// Else the side*side window (side is 2r+1) is read from the line store one
// tap per cycle through its single read port, then a restoring divider
// yields one quotient bit per cycle; the sums are SW (21 by default) bits wide.
// The result sits in an output register; a new word is accepted while it
// waits, but the next result holds until the receiver takes the old one.
// Reset restores the register defaults, clears the kernel and the position;
// the line store is not cleared and needs no sweep.
module rgb_kernel_blur #(
  parameter int unsigned MaxWidth  = rgbkb_pkg::DefMaxWidth,
  parameter int unsigned MaxRadius = rgbkb_pkg::DefMaxRadius
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rgbkb_in_if.sink                      in_ch,
  rgbkb_out_if.source                   out_ch,
  input  logic                          cfg_we_i,
  input  logic [rgbkb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rgbkb_pkg::CfgW-1:0]    cfg_data_i
);
  rgbkb_pkg::cmd_t    cmd;
  rgbkb_pkg::status_t status;
  logic [23:0]        out_pix;

  rgbkb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_op_i    (in_ch.op),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rgbkb_dp #(.MaxWidth(MaxWidth), .MaxRadius(MaxRadius)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .weight_index_i (in_ch.weight_index),
    .weight_value_i (in_ch.weight_value),
    .pix_i          ({in_ch.pix_b, in_ch.pix_g, in_ch.pix_r}),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_ch.ready),
    .out_valid_o    (out_ch.valid),
    .out_pix_o      (out_pix),
    .out_row_o      (out_ch.out_row),
    .out_col_o      (out_ch.out_col),
    .out_zero_o     (out_ch.zero_weight_sum)
  );

  assign out_ch.out_r = out_pix[7:0];
  assign out_ch.out_g = out_pix[15:8];
  assign out_ch.out_b = out_pix[23:16];
endmodule

// File: tb/rgb_kernel_blur_tb.sv
// Self-checking testbench for the RGB kernel blur: directed frames, then random frames.
`timescale 1ns / 1ps

module rgb_kernel_blur_tb;
  localparam int unsigned StoreRows = 2 * rgbkb_pkg::DefMaxRadius + 1;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 120;

  typedef struct {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [11:0] row;
    logic [9:0]  col;
    logic        zero_sum;
  } blur_px_t;

  class blur_scoreboard;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [1:0]  radius_reg;
    logic [23:0] lines [StoreRows*rgbkb_pkg::DefMaxWidth];
    logic [7:0]  weights [rgbkb_pkg::KSlots];
    int unsigned row_pos;
    int unsigned col_pos;
    blur_px_t    pending_px [$];
    int unsigned errors;

    function new();
      width_reg  = rgbkb_pkg::ResetWidth;
      height_reg = rgbkb_pkg::ResetHeight;
      radius_reg = rgbkb_pkg::ResetRadius;
      foreach (weights[i]) weights[i] = '0;
      row_pos = 0;
      col_pos = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [rgbkb_pkg::CfgIdxW-1:0] idx,
                            logic [rgbkb_pkg::CfgW-1:0] data);
      unique case (idx)
        rgbkb_pkg::RegFrameWidth:  width_reg = data[10:0];
        rgbkb_pkg::RegFrameHeight: height_reg = data;
        rgbkb_pkg::RegRadius:      radius_reg = data[1:0];
        default: return;
      endcase
      row_pos = 0;
      col_pos = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      return (width_reg > rgbkb_pkg::DefMaxWidth) ? rgbkb_pkg::DefMaxWidth : width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      return (height_reg > 4096) ? 4096 : height_reg;
    endfunction

    function int unsigned eff_r();
      return (radius_reg > rgbkb_pkg::DefMaxRadius) ? rgbkb_pkg::DefMaxRadius : radius_reg;
    endfunction

    // Predict the blurred pixel, if any, for one accepted word.
    function void note_word(logic op, logic [4:0] idx, logic [7:0] val,
                            logic [7:0] pr, logic [7:0] pg, logic [7:0] pb);
      int unsigned w, h, rad, side, row, col, sr, sg, sb, tot, wt, prow, pcol;
      logic [23:0] px;
      blur_px_t e;
      w = eff_w();
      h = eff_h();
      rad = eff_r();
      side = 2 * rad + 1;
      if (op == rgbkb_pkg::OpLoadWeight) begin
        if (idx < rgbkb_pkg::KSlots) weights[idx] = val;
        return;
      end
      row = row_pos;
      col = col_pos;
      if (col >= w) col = w - 1;
      if (row >= h) row = h - 1;
      lines[(row % StoreRows) * rgbkb_pkg::DefMaxWidth + col] = {pb, pg, pr};
      if (row >= 2 * rad && col >= 2 * rad) begin
        sr = 0; sg = 0; sb = 0; tot = 0;
        for (int i = 0; i < side; i++) begin
          for (int j = 0; j < side; j++) begin
            prow = row - 2 * rad + i;
            pcol = col - 2 * rad + j;
            wt = weights[(i * side + j) % rgbkb_pkg::KSlots];
            px = lines[(prow % StoreRows) * rgbkb_pkg::DefMaxWidth + pcol];
            tot += wt;
            sr += wt * px[7:0];
            sg += wt * px[15:8];
            sb += wt * px[23:16];
          end
        end
        if (tot == 0) begin
          e.r = '0; e.g = '0; e.b = '0; e.zero_sum = 1'b1;
        end else begin
          e.r = 8'(sr / tot); e.g = 8'(sg / tot); e.b = 8'(sb / tot);
          e.zero_sum = 1'b0;
        end
        e.row = 12'(row - rad);
        e.col = 10'(col - rad);
        pending_px.push_back(e);
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
      row_pos = row & 12'hFFF;
      col_pos = col & 10'h3FF;
    endfunction

    function void check_px(blur_px_t got);
      blur_px_t e;
      if (pending_px.size() == 0) begin
        $error("unexpected result word row=%0d col=%0d", got.row, got.col);
        errors++;
        return;
      end
      e = pending_px.pop_front();
      if (got.r !== e.r) begin
        $error("out_r expected %0d actual %0d", e.r, got.r); errors++;
      end
      if (got.g !== e.g) begin
        $error("out_g expected %0d actual %0d", e.g, got.g); errors++;
      end
      if (got.b !== e.b) begin
        $error("out_b expected %0d actual %0d", e.b, got.b); errors++;
      end
      if (got.row !== e.row) begin
        $error("out_row expected %0d actual %0d", e.row, got.row); errors++;
      end
      if (got.col !== e.col) begin
        $error("out_col expected %0d actual %0d", e.col, got.col); errors++;
      end
      if (got.zero_sum !== e.zero_sum) begin
        $error("zero_weight_sum expected %0d actual %0d", e.zero_sum, got.zero_sum);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rgbkb_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [rgbkb_pkg::CfgW-1:0] cfg_data_i = '0;
  bit idling = 1'b1;
  int unsigned pixel_words = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;

  rgbkb_in_if in_ch ();
  rgbkb_out_if out_ch ();

  blur_scoreboard sb = new();

  rgb_kernel_blur dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = rgbkb_pkg::OpPixel;
    in_ch.weight_index = '0;
    in_ch.weight_value = '0;
    in_ch.pix_r = '0;
    in_ch.pix_g = '0;
    in_ch.pix_b = '0;
  end

  // Result side: check accepted words, stall in random bursts while idling is set.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_px('{out_ch.out_r, out_ch.out_g, out_ch.out_b, out_ch.out_row,
                      out_ch.out_col, out_ch.zero_weight_sum});
      if (idling && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 8);
      out_ch.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_word(logic op, logic [4:0] idx, logic [7:0] val,
                           logic [7:0] pr, logic [7:0] pg, logic [7:0] pb);
    int unsigned gap;
    gap = 0;
    if (idling && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.weight_index <= idx;
    in_ch.weight_value <= val;
    in_ch.pix_r <= pr;
    in_ch.pix_g <= pg;
    in_ch.pix_b <= pb;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_word(op, idx, val, pr, pg, pb);
    if (op == rgbkb_pkg::OpPixel) pixel_words++;
  endtask

  task automatic send_pixel(logic [7:0] pr, logic [7:0] pg, logic [7:0] pb);
    send_word(rgbkb_pkg::OpPixel, 5'($urandom), 8'($urandom), pr, pg, pb);
  endtask

  task automatic send_weight(logic [4:0] idx, logic [7:0] val);
    send_word(rgbkb_pkg::OpLoadWeight, idx, val, 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  task automatic random_pixels(int unsigned n);
    for (int i = 0; i < n; i++) begin
      // Drop a stray weight load into the stream now and then.
      if ($urandom_range(0, 39) == 0) send_weight(5'($urandom), 8'($urandom));
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Hold the input low, wait for every result, then let the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure(logic [rgbkb_pkg::CfgW-1:0] w, logic [rgbkb_pkg::CfgW-1:0] h,
                           logic [rgbkb_pkg::CfgW-1:0] rad, bit poke_unknown);
    logic [rgbkb_pkg::CfgW-1:0] vals [4];
    int unsigned n;
    vals = '{w, h, rad, rgbkb_pkg::CfgW'($urandom)};
    n = poke_unknown ? 4 : 3;
    drain();
    for (int i = 0; i < n; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= rgbkb_pkg::CfgIdxW'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(rgbkb_pkg::CfgIdxW'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_kernel(bit all_zero);
    for (int i = 0; i < rgbkb_pkg::KSlots; i++)
      send_weight(5'(i), all_zero ? 8'd0 : 8'($urandom));
  endtask

  initial begin
    int unsigned w, h, rad, frame_px;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 3x3 frame, extreme weights and pixels, ignored indexes.
    configure(13'd3, 13'd3, 13'd1, 1'b1);
    send_weight(5'd0, 8'd255);
    for (int i = 1; i < 9; i++) send_weight(5'(i), 8'd1);
    send_weight(5'd31, 8'd77);
    send_weight(5'd25, 8'd200);
    for (int i = 0; i < 9; i++)
      send_pixel(i[0] ? 8'hFF : 8'h00, i[1] ? 8'hFF : 8'h00, 8'hFF);
    // Wrap to the next frame without a register write.
    random_pixels(9);

    // Zero weight sum.
    for (int i = 0; i < 9; i++) send_weight(5'(i), 8'd0);
    random_pixels(9);

    // Out-of-range registers saturate; too-small frames give nothing.
    configure(13'd0, 13'd0, 13'd3, 1'b0);
    load_kernel(1'b0);
    random_pixels(4);
    configure(13'd2047, 13'd8191, 13'd0, 1'b0);
    random_pixels(5);
    configure(13'd4, 13'd4, 13'd2, 1'b0);
    random_pixels(16);
    configure(13'd1024, 13'd1, 13'd0, 1'b0);
    random_pixels(1024);
    configure(13'd1, 13'd4096, 13'd0, 1'b0);
    random_pixels(200);

    while (pixel_words < 1480) begin
      if (pixel_words > 1400) idling = 1'b0;
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 2047);
        1: w = 1;
        default: w = $urandom_range(2, 12);
      endcase
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 9);
      rad = $urandom_range(0, 3);
      configure(rgbkb_pkg::CfgW'(w), rgbkb_pkg::CfgW'(h), rgbkb_pkg::CfgW'(rad),
                $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 2) == 0) load_kernel($urandom_range(0, 9) == 0);
      frame_px = sb.eff_w() * sb.eff_h() * $urandom_range(1, 2);
      if (frame_px > 120) frame_px = $urandom_range(20, 120);
      random_pixels(frame_px);
    end

    drain();
    if (sb.errors == 0 && sb.pending_px.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
